@@ hdl/mshe_pkg.sv @@
// Package for the multimode hash engine: types, codes, constants and round functions.
`timescale 1ns / 1ps
`default_nettype none
package mshe_pkg;

    // Algorithm codes
    localparam logic [2:0] ALG_SHA1   = 3'd0;
    localparam logic [2:0] ALG_SHA224 = 3'd1;
    localparam logic [2:0] ALG_SHA256 = 3'd2;
    localparam logic [2:0] ALG_SHA384 = 3'd3;
    localparam logic [2:0] ALG_SHA512 = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // One message word as classified by the front end
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  count;
        logic        last;
    } t_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TAKE,
        ST_PUT,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } t_state;

    // Status from back end to top
    typedef struct packed {
        logic busy;
    } t_status;

    function automatic logic [31:0] init_value(input logic [2:0] alg, input logic [3:0] i);
        logic [31:0] v;
        v = 32'h0;
        unique case (alg)
            ALG_SHA1: begin
                unique case (i)
                    4'd0: v = 32'h67452301; 4'd1: v = 32'hEFCDAB89;
                    4'd2: v = 32'h98BADCFE; 4'd3: v = 32'h10325476;
                    4'd4: v = 32'hC3D2E1F0; default: v = 32'h0;
                endcase
            end
            ALG_SHA224: begin
                unique case (i)
                    4'd0: v = 32'hC1059ED8; 4'd1: v = 32'h367CD507;
                    4'd2: v = 32'h3070DD17; 4'd3: v = 32'hF70E5939;
                    4'd4: v = 32'hFFC00B31; 4'd5: v = 32'h68581511;
                    4'd6: v = 32'h64F98FA7; 4'd7: v = 32'hBEFA4FA4;
                    default: v = 32'h0;
                endcase
            end
            ALG_SHA384: begin
                unique case (i)
                    4'd0: v = 32'hCBBB9D5D; 4'd1: v = 32'hC1059ED8;
                    4'd2: v = 32'h629A292A; 4'd3: v = 32'h367CD507;
                    4'd4: v = 32'h9159015A; 4'd5: v = 32'h3070DD17;
                    4'd6: v = 32'h152FECD8; 4'd7: v = 32'hF70E5939;
                    4'd8: v = 32'h67332667; 4'd9: v = 32'hFFC00B31;
                    4'd10: v = 32'h8EB44A87; 4'd11: v = 32'h68581511;
                    4'd12: v = 32'hDB0C2E0D; 4'd13: v = 32'h64F98FA7;
                    4'd14: v = 32'h47B5481D; default: v = 32'hBEFA4FA4;
                endcase
            end
            ALG_SHA512: begin
                unique case (i)
                    4'd0: v = 32'h6A09E667; 4'd1: v = 32'hF3BCC908;
                    4'd2: v = 32'hBB67AE85; 4'd3: v = 32'h84CAA73B;
                    4'd4: v = 32'h3C6EF372; 4'd5: v = 32'hFE94F82B;
                    4'd6: v = 32'hA54FF53A; 4'd7: v = 32'h5F1D36F1;
                    4'd8: v = 32'h510E527F; 4'd9: v = 32'hADE682D1;
                    4'd10: v = 32'h9B05688C; 4'd11: v = 32'h2B3E6C1F;
                    4'd12: v = 32'h1F83D9AB; 4'd13: v = 32'hFB41BD6B;
                    4'd14: v = 32'h5BE0CD19; default: v = 32'h137E2179;
                endcase
            end
            default: begin
                unique case (i)
                    4'd0: v = 32'h6A09E667; 4'd1: v = 32'hBB67AE85;
                    4'd2: v = 32'h3C6EF372; 4'd3: v = 32'hA54FF53A;
                    4'd4: v = 32'h510E527F; 4'd5: v = 32'h9B05688C;
                    4'd6: v = 32'h1F83D9AB; 4'd7: v = 32'h5BE0CD19;
                    default: v = 32'h0;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [63:0] round_const(input logic [6:0] i);
        logic [63:0] k;
        unique case (i)
            7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

@@ hdl/mshe_front.sv @@
// Front end: accepts message words, clamps byte counts and queues them.
`timescale 1ns / 1ps
`default_nettype none
module mshe_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_flush,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire  [39:0]          s_axis_tdata,
    input  wire                  s_axis_tlast,
    output logic                 o_q_valid,
    input  wire                  i_q_pop,
    output mshe_pkg::t_word      o_q_word
);
    import mshe_pkg::*;

    t_word                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wptr, r_rptr;
    logic [QUEUE_AW:0]     r_cnt;
    t_word                 w_in;
    logic                  w_push, w_pop;

    // Classify: clamp byte count above four
    always_comb begin
        w_in.data  = s_axis_tdata[31:0];
        w_in.count = (s_axis_tdata[34:32] > 3'd4) ? 3'd4 : s_axis_tdata[34:32];
        w_in.last  = s_axis_tlast;
    end

    assign s_axis_tready = (r_cnt != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign w_push = s_axis_tvalid && s_axis_tready;
    assign o_q_valid = (r_cnt != '0);
    assign w_pop = i_q_pop && o_q_valid;
    assign o_q_word = r_mem[r_rptr];

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_in;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) r_wptr <= r_wptr + 1'b1;
            if (w_pop)  r_rptr <= r_rptr + 1'b1;
            r_cnt <= r_cnt + (QUEUE_AW+1)'(w_push) - (QUEUE_AW+1)'(w_pop);
        end
    end
endmodule
`default_nettype wire

@@ hdl/mshe_back.sv @@
// Back end: packs bytes, pads, runs compression rounds and emits the digest.
`timescale 1ns / 1ps
`default_nettype none
module mshe_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire  [2:0]           i_cfg_alg,
    input  wire                  i_q_valid,
    output logic                 o_q_pop,
    input  mshe_pkg::t_word      i_q_word,
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [31:0]          m_axis_tdata,
    output logic                 m_axis_tlast,
    output logic                 m_axis_tuser,
    output mshe_pkg::t_status    o_status
);
    import mshe_pkg::*;

    t_state       r_state, n_state;
    logic [2:0]   r_alg;
    logic [31:0]  r_cv [16];
    logic [31:0]  r_blk [32];
    logic [7:0]   r_fill;
    logic [63:0]  r_len;
    logic         r_ovf;
    t_word        r_word;
    logic [2:0]   r_bi;           // byte index within current word
    logic         r_last;
    logic [1:0]   r_pad;          // 0 marker, 1 zeros, 2 length
    logic [63:0]  r_s [8];        // working variables
    logic [63:0]  r_w [16];       // schedule window
    logic [6:0]   r_rnd;
    logic [4:0]   r_oi;
    logic         r_ovalid;
    logic [31:0]  r_odata;
    logic         r_olast, r_ouser;

    logic         w_wide, w_sha1;
    logic [7:0]   w_blkbytes;
    logic [6:0]   w_rounds;
    logic [4:0]   w_dwords;
    logic [7:0]   w_byte;
    logic         w_fillnow;
    logic [7:0]   w_fnext;
    logic [63:0]  w_lenadd;
    logic         w_emit;

    assign w_sha1     = (r_alg == ALG_SHA1);
    assign w_wide     = (r_alg == ALG_SHA384) || (r_alg == ALG_SHA512);
    assign w_blkbytes = w_wide ? 8'd128 : 8'd64;
    assign w_rounds   = w_wide || w_sha1 ? 7'd80 : 7'd64;
    always_comb begin
        unique case (r_alg)
            ALG_SHA1:   w_dwords = 5'd5;
            ALG_SHA224: w_dwords = 5'd7;
            ALG_SHA384: w_dwords = 5'd12;
            ALG_SHA512: w_dwords = 5'd16;
            default:    w_dwords = 5'd8;
        endcase
    end

    // Byte to place in the current step
    always_comb begin
        w_byte = 8'h00;
        priority case (r_state)
            ST_PUT: begin
                unique case (r_bi[1:0])
                    2'd0: w_byte = r_word.data[31:24];
                    2'd1: w_byte = r_word.data[23:16];
                    2'd2: w_byte = r_word.data[15:8];
                    default: w_byte = r_word.data[7:0];
                endcase
            end
            ST_PAD: begin
                if (r_pad == 2'd0) w_byte = 8'h80;
                else if (r_pad == 2'd2) w_byte = r_len[8'd63 - {r_fill[2:0], 3'd0} -: 8];
                else w_byte = 8'h00;
            end
            default: w_byte = 8'h00;
        endcase
    end

    assign w_fnext   = r_fill + 8'd1;
    assign w_fillnow = (w_fnext == w_blkbytes);
    assign w_lenadd  = {58'd0, i_q_word.count, 3'd0};
    assign w_emit    = (r_state == ST_EMIT) && (!r_ovalid || m_axis_tready)
                     && (r_oi != w_dwords);

    // Round datapath
    logic [63:0] w_wt, w_kt, w_t1, w_t2, w_wnew, w_sig0, w_sig1;
    logic [31:0] w_f1, w_k1, w_t1s;
    logic [63:0] w_ch, w_maj, w_bs0, w_bs1;
    always_comb begin
        w_wt = r_w[0];
        w_kt = round_const(r_rnd);
        w_ch  = (r_s[4] & r_s[5]) ^ (~r_s[4] & r_s[6]);
        w_maj = (r_s[0] & r_s[1]) ^ (r_s[0] & r_s[2]) ^ (r_s[1] & r_s[2]);
        if (w_wide) begin
            w_bs1 = {r_s[4][13:0], r_s[4][63:14]} ^ {r_s[4][17:0], r_s[4][63:18]}
                  ^ {r_s[4][40:0], r_s[4][63:41]};
            w_bs0 = {r_s[0][27:0], r_s[0][63:28]} ^ {r_s[0][33:0], r_s[0][63:34]}
                  ^ {r_s[0][38:0], r_s[0][63:39]};
            w_sig1 = {r_w[14][18:0], r_w[14][63:19]} ^ {r_w[14][60:0], r_w[14][63:61]}
                   ^ (r_w[14] >> 6);
            w_sig0 = {r_w[1][0], r_w[1][63:1]} ^ {r_w[1][7:0], r_w[1][63:8]}
                   ^ (r_w[1] >> 7);
            w_t1 = r_s[7] + w_bs1 + w_ch + w_kt + w_wt;
            w_t2 = w_bs0 + w_maj;
            w_wnew = w_sig1 + r_w[9] + w_sig0 + r_w[0];
        end else begin
            w_bs1 = {32'd0, {r_s[4][5:0], r_s[4][31:6]} ^ {r_s[4][10:0], r_s[4][31:11]}
                  ^ {r_s[4][24:0], r_s[4][31:25]}};
            w_bs0 = {32'd0, {r_s[0][1:0], r_s[0][31:2]} ^ {r_s[0][12:0], r_s[0][31:13]}
                  ^ {r_s[0][21:0], r_s[0][31:22]}};
            w_sig1 = {32'd0, {r_w[14][16:0], r_w[14][31:17]}
                   ^ {r_w[14][18:0], r_w[14][31:19]} ^ (r_w[14][31:0] >> 10)};
            w_sig0 = {32'd0, {r_w[1][6:0], r_w[1][31:7]}
                   ^ {r_w[1][17:0], r_w[1][31:18]} ^ (r_w[1][31:0] >> 3)};
            w_t1 = {32'd0, r_s[7][31:0] + w_bs1[31:0] + w_ch[31:0] + w_kt[63:32]
                   + w_wt[31:0]};
            w_t2 = {32'd0, w_bs0[31:0] + w_maj[31:0]};
            if (w_sha1) begin
                w_wnew = {32'd0, {r_w[13][30:0] ^ r_w[8][30:0] ^ r_w[2][30:0] ^ r_w[0][30:0],
                          r_w[13][31] ^ r_w[8][31] ^ r_w[2][31] ^ r_w[0][31]}};
            end else begin
                w_wnew = {32'd0, w_sig1[31:0] + r_w[9][31:0] + w_sig0[31:0] + r_w[0][31:0]};
            end
        end
        // SHA-1 round
        if (r_rnd < 7'd20) begin
            w_f1 = (r_s[1][31:0] & r_s[2][31:0]) ^ (~r_s[1][31:0] & r_s[3][31:0]);
            w_k1 = 32'h5A827999;
        end else if (r_rnd < 7'd40) begin
            w_f1 = r_s[1][31:0] ^ r_s[2][31:0] ^ r_s[3][31:0];
            w_k1 = 32'h6ED9EBA1;
        end else if (r_rnd < 7'd60) begin
            w_f1 = (r_s[1][31:0] & r_s[2][31:0]) ^ (r_s[1][31:0] & r_s[3][31:0])
                 ^ (r_s[2][31:0] & r_s[3][31:0]);
            w_k1 = 32'h8F1BBCDC;
        end else begin
            w_f1 = r_s[1][31:0] ^ r_s[2][31:0] ^ r_s[3][31:0];
            w_k1 = 32'hCA62C1D6;
        end
        w_t1s = {r_s[0][26:0], r_s[0][31:27]} + w_f1 + r_s[4][31:0] + w_wt[31:0] + w_k1;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = ST_TAKE;
                end
            end
            ST_TAKE: n_state = (r_word.count == 3'd0) ? (r_last ? ST_PAD : ST_IDLE) : ST_PUT;
            ST_PUT: begin
                if (w_fillnow) n_state = ST_LOAD;
                else if (r_bi + 3'd1 == r_word.count) n_state = r_last ? ST_PAD : ST_IDLE;
            end
            ST_PAD: if (w_fillnow) n_state = ST_LOAD;
            ST_LOAD: n_state = ST_ROUND;
            ST_ROUND: if (r_rnd == w_rounds - 7'd1) n_state = ST_ADD;
            ST_ADD: begin
                if (r_pad == 2'd2) n_state = ST_EMIT;
                else if (r_state == ST_ADD && r_bi < r_word.count && !r_last)
                    n_state = ST_PUT;
                else if (r_bi < r_word.count) n_state = ST_PUT;
                else if (r_last) n_state = ST_PAD;
                else n_state = ST_IDLE;
            end
            ST_EMIT: begin
                if ((!r_ovalid || m_axis_tready) && r_oi == w_dwords) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    // Block store writes
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PUT || r_state == ST_PAD) begin
            unique case (r_fill[1:0])
                2'd0: r_blk[r_fill[6:2]] <= {w_byte, 24'd0};
                2'd1: r_blk[r_fill[6:2]][23:16] <= w_byte;
                2'd2: r_blk[r_fill[6:2]][15:8] <= w_byte;
                default: r_blk[r_fill[6:2]][7:0] <= w_byte;
            endcase
        end
    end

    // Output valid: raise on each emitted word, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (w_emit) r_ovalid <= 1'b1;
        else if (m_axis_tready) r_ovalid <= 1'b0;
    end

    // Control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alg <= ALG_SHA256;
            r_fill <= '0;
            r_len <= '0;
            r_ovf <= 1'b0;
            r_pad <= 2'd0;
            r_oi <= '0;
            r_bi <= '0;
            r_last <= 1'b0;
            for (int i = 0; i < 16; i++) r_cv[i] <= init_value(ALG_SHA256, 4'(i));
        end else begin
            if (i_cfg_we && i_cfg_alg <= ALG_SHA512) begin
                r_alg <= i_cfg_alg;
                r_fill <= '0;
                r_len <= '0;
                r_ovf <= 1'b0;
                for (int i = 0; i < 16; i++) r_cv[i] <= init_value(i_cfg_alg, 4'(i));
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_word <= i_q_word;
                        r_last <= i_q_word.last;
                        r_bi <= '0;
                        r_pad <= 2'd0;
                        r_len <= r_len + w_lenadd;
                        if (r_len + w_lenadd < r_len) r_ovf <= 1'b1;
                    end
                end
                ST_PUT: begin
                    r_bi <= r_bi + 3'd1;
                    r_fill <= w_fillnow ? 8'd0 : w_fnext;
                end
                ST_PAD: begin
                    r_fill <= w_fillnow ? 8'd0 : w_fnext;
                    if (r_pad != 2'd2 && w_fnext == w_blkbytes - 8'd8) r_pad <= 2'd2;
                    else if (r_pad == 2'd0) r_pad <= 2'd1;
                end
                ST_LOAD: begin
                    r_rnd <= '0;
                    for (int i = 0; i < 8; i++) begin
                        r_s[i] <= w_wide ? {r_cv[2*i], r_cv[2*i+1]} : {32'd0, r_cv[i]};
                    end
                    for (int i = 0; i < 16; i++) begin
                        r_w[i] <= w_wide ? {r_blk[2*i], r_blk[2*i+1]} : {32'd0, r_blk[i]};
                    end
                end
                ST_ROUND: begin
                    r_rnd <= r_rnd + 7'd1;
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_wnew;
                    if (w_sha1) begin
                        r_s[0] <= {32'd0, w_t1s};
                        r_s[1] <= r_s[0];
                        r_s[2] <= {32'd0, r_s[1][1:0], r_s[1][31:2]};
                        r_s[3] <= r_s[2];
                        r_s[4] <= r_s[3];
                    end else if (w_wide) begin
                        r_s[0] <= w_t1 + w_t2;
                        for (int i = 1; i < 8; i++) begin
                            if (i != 4) r_s[i] <= r_s[i-1];
                        end
                        r_s[4] <= r_s[3] + w_t1;
                    end else begin
                        r_s[0] <= {32'd0, w_t1[31:0] + w_t2[31:0]};
                        for (int i = 1; i < 8; i++) begin
                            if (i != 4) r_s[i] <= r_s[i-1];
                        end
                        r_s[4] <= {32'd0, r_s[3][31:0] + w_t1[31:0]};
                    end
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        if (w_wide) begin
                            {r_cv[2*i], r_cv[2*i+1]} <= {r_cv[2*i], r_cv[2*i+1]} + r_s[i];
                        end else if (!w_sha1 || i < 5) begin
                            r_cv[i] <= r_cv[i] + r_s[i][31:0];
                        end
                    end
                    r_oi <= '0;
                end
                ST_EMIT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        if (r_oi == w_dwords) begin
                            r_fill <= '0;
                            r_len <= '0;
                            r_ovf <= 1'b0;
                            for (int i = 0; i < 16; i++) r_cv[i] <= init_value(r_alg, 4'(i));
                        end else begin
                            r_odata <= r_cv[r_oi[3:0]];
                            r_olast <= (r_oi == w_dwords - 5'd1);
                            r_ouser <= r_ovf;
                            r_oi <= r_oi + 5'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ouser;
    assign o_status.busy = (r_state != ST_IDLE) || r_ovalid;
endmodule
`default_nettype wire

@@ hdl/multimode_sha_hash_engine.sv @@
// Top level of the multimode hash engine: front queue, back compression core.
// Usage:
//  s_axis carries message words: tdata[31:0] message_word, tdata[34:32] byte_count,
//  tlast marks the last word. Words enter a four-entry queue, so the sender
//  is stalled only when the queue is full.
//  m_axis carries digest words (tdata), tlast on the final one, tuser the
//  length overflow flag. A stalled receiver holds the output register and
//  the core waits; the input queue keeps filling meanwhile.
//  i_cfg_* writes the algorithm (0..4); other values are ignored. Write only
//  while idle; a write restarts the message.
//  Flow: each word is taken from the queue and packed byte by byte; every
//  full block is loaded, run through its compression rounds by the
//  one-round-per-cycle compression unit and added to the chain value. The
//  last word adds the pad bytes, the final block(s), the digest words and
//  a reload of the initial values.
//  Reset (synchronous, low) selects SHA-256, loads its initial values and
//  empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module multimode_sha_hash_engine (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // message_word[31:0], byte_count[34:32], zero
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word[31:0]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // length_overflow
);
    import mshe_pkg::*;

    logic    w_qv, w_pop, w_cfg_we;
    t_word   w_qw;
    t_status w_st;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we = i_cfg_valid;

    mshe_front u_front (
        .i_clk, .i_rst_n, .i_flush(1'b0),
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
        .o_q_valid(w_qv), .i_q_pop(w_pop), .o_q_word(w_qw)
    );

    mshe_back u_back (
        .i_clk, .i_rst_n, .i_cfg_we(w_cfg_we), .i_cfg_alg(i_cfg_data),
        .i_q_valid(w_qv), .o_q_pop(w_pop), .i_q_word(w_qw),
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
        .o_status(w_st)
    );

    // Output only while the core is busy
    assert property (@(posedge i_clk) disable iff (!i_rst_n) m_axis_tvalid |-> w_st.busy)
        else $error("digest word without busy core");
    // A stalled digest word holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("digest word changed under stall");
endmodule
`default_nettype wire

@@ verif/multimode_sha_hash_engine_tb.sv @@
// Testbench for the multimode hash engine: directed and random messages checked against a digest predictor.
`timescale 1ns / 1ps
module multimode_sha_hash_engine_tb;
    import mshe_pkg::*;

    // Round constants, SHA-256 uses the upper halves of the first 64
    localparam bit [63:0] RK [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam bit [31:0] IV [5][16] = '{
        '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0,
          0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
          32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4, 0, 0, 0, 0, 0, 0, 0, 0},
        '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
          32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19, 0, 0, 0, 0, 0, 0, 0, 0},
        '{32'hCBBB9D5D, 32'hC1059ED8, 32'h629A292A, 32'h367CD507,
          32'h9159015A, 32'h3070DD17, 32'h152FECD8, 32'hF70E5939,
          32'h67332667, 32'hFFC00B31, 32'h8EB44A87, 32'h68581511,
          32'hDB0C2E0D, 32'h64F98FA7, 32'h47B5481D, 32'hBEFA4FA4},
        '{32'h6A09E667, 32'hF3BCC908, 32'hBB67AE85, 32'h84CAA73B,
          32'h3C6EF372, 32'hFE94F82B, 32'hA54FF53A, 32'h5F1D36F1,
          32'h510E527F, 32'hADE682D1, 32'h9B05688C, 32'h2B3E6C1F,
          32'h1F83D9AB, 32'hFB41BD6B, 32'h5BE0CD19, 32'h137E2179}
    };

    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic        overflow;
    } t_digest;

    // Digest predictor and store of expected digest words
    class digest_scoreboard;
        bit [2:0]  alg;
        bit [31:0] chain [16];
        bit [31:0] blk [32];
        int        fill;
        bit [63:0] bit_len;
        bit        ovf;
        t_digest   expected_digest [$];
        int        errors;

        function new();
            alg = ALG_SHA256;
            foreach (blk[i]) blk[i] = '0;
            errors = 0;
            restart();
        endfunction

        function void restart();
            foreach (chain[i]) chain[i] = IV[alg][i];
            fill = 0;
            bit_len = '0;
            ovf = 1'b0;
        endfunction

        function void set_algorithm(bit [2:0] v);
            if (v > ALG_SHA512) return;
            alg = v;
            restart();
        endfunction

        function bit [31:0] rl32(bit [31:0] x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function bit [63:0] rr64(bit [63:0] x, int n);
            return (x >> n) | (x << (64 - n));
        endfunction

        function void compress_sha1();
            bit [31:0] w [80];
            bit [31:0] a, b, c, d, e, f, k, t;
            for (int i = 0; i < 16; i++) w[i] = blk[i];
            for (int i = 16; i < 80; i++) w[i] = rl32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
            for (int i = 0; i < 80; i++) begin
                if (i < 20) begin
                    f = (b & c) ^ (~b & d); k = 32'h5A827999;
                end else if (i < 40) begin
                    f = b ^ c ^ d; k = 32'h6ED9EBA1;
                end else if (i < 60) begin
                    f = (b & c) ^ (b & d) ^ (c & d); k = 32'h8F1BBCDC;
                end else begin
                    f = b ^ c ^ d; k = 32'hCA62C1D6;
                end
                t = rl32(a, 5) + f + e + w[i] + k;
                e = d; d = c; c = rl32(b, 30); b = a; a = t;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
        endfunction

        function void compress_sha256();
            bit [31:0] w [64];
            bit [31:0] s [8];
            bit [31:0] t1, t2;
            for (int i = 0; i < 16; i++) w[i] = blk[i];
            for (int i = 16; i < 64; i++)
                w[i] = (rl32(w[i-2], 15) ^ rl32(w[i-2], 13) ^ (w[i-2] >> 10)) + w[i-7] +
                       (rl32(w[i-15], 25) ^ rl32(w[i-15], 14) ^ (w[i-15] >> 3)) + w[i-16];
            for (int i = 0; i < 8; i++) s[i] = chain[i];
            for (int i = 0; i < 64; i++) begin
                t1 = s[7] + (rl32(s[4], 26) ^ rl32(s[4], 21) ^ rl32(s[4], 7)) +
                     ((s[4] & s[5]) ^ (~s[4] & s[6])) + RK[i][63:32] + w[i];
                t2 = (rl32(s[0], 30) ^ rl32(s[0], 19) ^ rl32(s[0], 10)) +
                     ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
                s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
                s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) chain[i] += s[i];
        endfunction

        function void compress_sha512();
            bit [63:0] w [80];
            bit [63:0] s [8];
            bit [63:0] t1, t2, h;
            for (int i = 0; i < 16; i++) w[i] = {blk[2*i], blk[2*i+1]};
            for (int i = 16; i < 80; i++)
                w[i] = (rr64(w[i-2], 19) ^ rr64(w[i-2], 61) ^ (w[i-2] >> 6)) + w[i-7] +
                       (rr64(w[i-15], 1) ^ rr64(w[i-15], 8) ^ (w[i-15] >> 7)) + w[i-16];
            for (int i = 0; i < 8; i++) s[i] = {chain[2*i], chain[2*i+1]};
            for (int i = 0; i < 80; i++) begin
                t1 = s[7] + (rr64(s[4], 14) ^ rr64(s[4], 18) ^ rr64(s[4], 41)) +
                     ((s[4] & s[5]) ^ (~s[4] & s[6])) + RK[i] + w[i];
                t2 = (rr64(s[0], 28) ^ rr64(s[0], 34) ^ rr64(s[0], 39)) +
                     ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
                s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
                s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) begin
                h = {chain[2*i], chain[2*i+1]} + s[i];
                chain[2*i] = h[63:32];
                chain[2*i+1] = h[31:0];
            end
        endfunction

        function void put_byte(bit [7:0] b);
            int idx, pos;
            idx = (fill >> 2) & 31;
            pos = fill & 3;
            if (pos == 0) blk[idx] = {b, 24'h0};
            else blk[idx] |= 32'(b) << ((3 - pos) * 8);
            fill++;
            if (fill >= ((alg >= ALG_SHA384) ? 128 : 64)) begin
                if (alg == ALG_SHA1) compress_sha1();
                else if (alg <= ALG_SHA256) compress_sha256();
                else compress_sha512();
                fill = 0;
            end
        endfunction

        // Absorb one accepted message word; on the last one queue the digest
        function void note_word(bit [31:0] w, bit [2:0] cnt, bit last);
            int n, pad_end;
            bit [63:0] grown;
            t_digest d;
            if (cnt > 4) cnt = 4;
            for (int i = 0; i < cnt; i++) put_byte(w[31 - 8*i -: 8]);
            grown = bit_len + 64'(8 * cnt);
            if (grown < bit_len) ovf = 1'b1;
            bit_len = grown;
            if (!last) return;
            put_byte(8'h80);
            pad_end = ((alg >= ALG_SHA384) ? 128 : 64) - 8;
            while (fill != pad_end) put_byte(8'h00);
            for (int i = 0; i < 8; i++) put_byte(bit_len[63 - 8*i -: 8]);
            case (alg)
                ALG_SHA1:   n = 5;
                ALG_SHA224: n = 7;
                ALG_SHA384: n = 12;
                ALG_SHA512: n = 16;
                default:    n = 8;
            endcase
            for (int j = 0; j < n; j++) begin
                d.word = chain[j];
                d.last = (j == n - 1);
                d.overflow = ovf;
                expected_digest.push_back(d);
            end
            restart();
        endfunction

        function void check_digest(bit [31:0] w, bit last, bit overflow);
            t_digest d;
            if (expected_digest.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected digest word %h", w);
                return;
            end
            d = expected_digest.pop_front();
            if (d.word !== w || d.last !== last || d.overflow !== overflow) begin
                errors++;
                if (errors <= 10)
                    $display("digest mismatch: exp %h last %b ovf %b, got %h last %b ovf %b",
                             d.word, d.last, d.overflow, w, last, overflow);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;    // message_word[31:0], byte_count[34:32], zero
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // digest_word[31:0]
    logic        m_axis_tlast;
    logic        m_axis_tuser;         // length_overflow

    digest_scoreboard sb = new();
    int  words_sent = 0;
    bit  hold_req = 1'b0;

    always #1 i_clk = ~i_clk;

    multimode_sha_hash_engine uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser)
    );

    // Note accepted words and check digest words
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_word(s_axis_tdata[31:0], s_axis_tdata[34:32], s_axis_tlast);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_digest(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) return 0;
        if (r < 17) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, one long hold-off once asked for
    initial begin
        int gap;
        bit held;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !held) begin
                m_axis_tready = 1'b0;
                repeat (400) @(negedge i_clk);
                held = 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                m_axis_tready = 1'b1;
                repeat ($urandom_range(20, 60)) @(negedge i_clk);
            end else begin
                gap = pick_gap();
                m_axis_tready = (gap == 0);
                if (gap > 1) repeat (gap - 1) @(negedge i_clk);
            end
        end
    end

    task automatic send_word(bit [31:0] w, bit [2:0] cnt, bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata = {5'b0, cnt, w};
        s_axis_tlast = last;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        words_sent++;
    endtask

    // Hold until every digest is out and the core has gone quiet
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.expected_digest.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_algorithm(bit [2:0] v);
        drain();
        i_cfg_data = v;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_algorithm(v);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Mostly full words; now and then a short or oversized count mid-message
    task automatic send_message(int nwords);
        bit [2:0] cnt;
        for (int i = 0; i < nwords - 1; i++) begin
            cnt = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            send_word($urandom, cnt, 1'b0);
        end
        send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
    endtask

    initial begin
        int nmsg;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: known short message, empty message, extremes, short and oversized counts
        send_word(32'h61626300, 3'd3, 1'b1);
        send_word(32'h0, 3'd0, 1'b1);
        send_word(32'hFFFFFFFF, 3'd4, 1'b0);
        send_word(32'hFFFFFFFF, 3'd7, 1'b0);
        send_word(32'h00000000, 3'd2, 1'b0);
        send_word(32'h12345678, 3'd1, 1'b1);
        for (int a = ALG_SHA1; a <= ALG_SHA512; a++) begin
            write_algorithm(3'(a));
            send_word(32'h0, 3'd0, 1'b1);
            send_word(32'hFFFFFFFF, 3'd5, 1'b1);
        end
        write_algorithm(3'd7);
        send_word(32'hA5A5A5A5, 3'd4, 1'b1);

        // Long receiver hold-off while messages keep coming, so the queue fills
        write_algorithm(ALG_SHA256);
        hold_req = 1'b1;
        for (int m = 0; m < 3; m++) send_message(6);

        // Random phases, some with ignored algorithm values
        while (words_sent < 170) begin
            write_algorithm(3'($urandom_range(0, 7)));
            nmsg = $urandom_range(1, 4);
            for (int m = 0; m < nmsg; m++)
                send_message(($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 12));
        end

        drain();
        if (sb.errors == 0 && sb.expected_digest.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
